>>> sv/unsigned_decimal_field_formatter_defines.svh
`ifndef UNSIGNED_DECIMAL_FIELD_FORMATTER_DEFINES_SVH
`define UNSIGNED_DECIMAL_FIELD_FORMATTER_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low
`define UDFF_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low
`define UDFF_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/udff_pkg.sv
`default_nettype none

package udff_pkg;

  // Defaults for the top level parameters
  localparam int MAX_FIELD_DEF  = 63;
  localparam int VALUE_BITS_DEF = 32;

  // Fixed widths of the transaction fields
  localparam int VALUE_W = 32;
  localparam int FIELD_W = 6;
  localparam int CHAR_W  = 8;

  // One BCD digit per cell
  localparam int DIGIT_W = 4;
  localparam logic [DIGIT_W-1:0] BCD_ADJ_MIN = 4'd5;
  localparam logic [DIGIT_W-1:0] BCD_ADJ_ADD = 4'd3;

  // ASCII codes
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;

  // Control handed to every digit cell
  typedef struct packed {
    logic clear;
    logic shift;
  } cell_ctrl_t;

endpackage

`default_nettype wire

>>> sv/udff_bcd_cell.sv
`default_nettype none

module udff_bcd_cell
  import udff_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire cell_ctrl_t         ctrl_i,
  input  wire logic               carry_i,
  output logic                    carry_o,
  output logic [DIGIT_W-1:0]      digit_o
);

  logic [DIGIT_W-1:0] digit_q;
  logic [DIGIT_W-1:0] digit_d;
  logic [DIGIT_W-1:0] adj;

  // Add three to digits of five and up, then shift in the lower neighbor's bit
  always_comb begin
    adj     = (digit_q >= BCD_ADJ_MIN) ? (digit_q + BCD_ADJ_ADD) : digit_q;
    digit_d = digit_q;
    if (ctrl_i.clear) begin
      digit_d = '0;
    end else if (ctrl_i.shift) begin
      digit_d = {adj[DIGIT_W-2:0], carry_i};
    end
  end

  assign carry_o = adj[DIGIT_W-1];
  assign digit_o = digit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      digit_q <= '0;
    end else begin
      digit_q <= digit_d;
    end
  end

endmodule

`default_nettype wire

>>> sv/unsigned_decimal_field_formatter.sv
// Formats an unsigned number as a printf %u field and sends it out one ASCII
// character per transaction, with last_char_o on the final one. A row of BCD
// digit cells converts the value by shift-and-add-three, one value bit per
// cycle; the ST_PREP and ST_PLAN states follow, then one character per cycle
// while the output side does not stall. The field is as long as the largest
// of field width and digit count or precision, and a field that prints
// nothing returns to idle without any output. A new item is taken once the
// previous item's last character sits in the output register.
`default_nettype none

module unsigned_decimal_field_formatter
  import udff_pkg::*;
#(
  parameter int MAX_FIELD  = MAX_FIELD_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                valid_i,
  output logic                     stall_o,
  input  wire logic [VALUE_W-1:0]  value_i,
  input  wire logic [FIELD_W-1:0]  field_width_i,
  input  wire logic [FIELD_W-1:0]  min_digits_i,
  input  wire logic                has_precision_i,
  input  wire logic                left_justify_i,
  input  wire logic                pad_with_zero_i,
  output logic                     valid_o,
  input  wire logic                stall_i,
  output logic [CHAR_W-1:0]        character_o,
  output logic                     last_char_o
);

`include "unsigned_decimal_field_formatter_defines.svh"

  localparam int NDIG    = (VALUE_BITS * 30103) / 100000 + 1;
  localparam int CNT_MAX = (MAX_FIELD > NDIG) ? MAX_FIELD : NDIG;
  localparam int CW      = $clog2(CNT_MAX + 1);
  localparam int NDW     = $clog2(NDIG + 1);
  localparam int DIW     = $clog2(NDIG);
  localparam int BCW     = $clog2(VALUE_BITS + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_PREP,
    ST_PLAN,
    ST_EMIT
  } state_e;

  state_e                  state_q;
  logic [VALUE_BITS-1:0]   val_q;
  logic [BCW-1:0]          bcnt_q;
  logic [CW-1:0]           width_q;
  logic [CW-1:0]           prec_q;
  logic                    dot_q;
  logic                    left_q;
  logic                    zpad_q;
  logic [NDW-1:0]          ndig_q;
  logic [CW-1:0]           b1_q;
  logic [CW-1:0]           b2_q;
  logic [CW-1:0]           pos_q;
  logic [CW-1:0]           last_pos_q;
  logic [DIW-1:0]          dig_idx_q;
  logic                    out_valid_q;
  logic [CHAR_W-1:0]       out_char_q;
  logic                    out_last_q;

  logic                        accept;
  logic                        adv;
  cell_ctrl_t                  cell_ctrl;
  logic [NDIG:0]               carry;
  logic [DIGIT_W-1:0]          dig [NDIG];
  logic [VALUE_W+VALUE_BITS-1:0] val_ext;
  logic [CW-1:0]               width_sat;
  logic [CW-1:0]               prec_sat;
  logic [NDW-1:0]              ndig_c;

  logic [CW-1:0]     ndig_w;
  logic              use_prec;
  logic [CW-1:0]     body;
  logic [CW-1:0]     zeros;
  logic [CW-1:0]     pad;
  logic [CW-1:0]     total;
  logic [CW-1:0]     b1_c;
  logic [CW-1:0]     b2_c;

  logic              in_b1;
  logic              in_b2;
  logic              digit_sel;
  logic              is_last;
  logic [CHAR_W-1:0] pad_char;
  logic [CHAR_W-1:0] dig_char;
  logic [CHAR_W-1:0] ch;

  assign accept      = valid_i && !stall_o;
  assign stall_o     = (state_q != ST_IDLE);
  assign adv         = !out_valid_q || !stall_i;
  assign valid_o     = out_valid_q;
  assign character_o = out_char_q;
  assign last_char_o = out_last_q;

  // Take the low VALUE_BITS bits of the value, zero-extended
  assign val_ext = {{VALUE_BITS{1'b0}}, value_i};

  // Saturate width and precision
  always_comb begin
    width_sat = (int'(field_width_i) > MAX_FIELD) ? CW'(MAX_FIELD) : CW'(field_width_i);
    prec_sat  = (int'(min_digits_i) > MAX_FIELD) ? CW'(MAX_FIELD) : CW'(min_digits_i);
  end

  // Drive the digit row: clear on a new transaction, shift while converting
  assign cell_ctrl.clear = accept;
  assign cell_ctrl.shift = (state_q == ST_CONV);
  assign carry[0]        = val_q[VALUE_BITS-1];

  for (genvar k = 0; k < NDIG; k++) begin : g_cell
    udff_bcd_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (cell_ctrl),
      .carry_i (carry[k]),
      .carry_o (carry[k+1]),
      .digit_o (dig[k])
    );
  end

  // Count significant digits; zero with precision zero has none
  always_comb begin
    ndig_c = '0;
    for (int k = 0; k < NDIG; k++) begin
      if (dig[k] != '0) begin
        ndig_c = NDW'(k + 1);
      end
    end
    if (ndig_c == '0 && !(dot_q && prec_q == '0)) begin
      ndig_c = NDW'(1);
    end
  end

  // Lay out the field: pad, precision zeros, digits; the pad goes last when left-justified
  always_comb begin
    ndig_w   = CW'(ndig_q);
    use_prec = dot_q && (prec_q > ndig_w);
    body     = use_prec ? prec_q : ndig_w;
    zeros    = use_prec ? (prec_q - ndig_w) : '0;
    pad      = (width_q > body) ? (width_q - body) : '0;
    total    = (width_q > body) ? width_q : body;
    b1_c     = left_q ? zeros : pad;
    b2_c     = left_q ? body : (total - ndig_w);
  end

  // Pick the character at the current position
  always_comb begin
    in_b1     = (pos_q < b1_q);
    in_b2     = (pos_q < b2_q);
    digit_sel = left_q ? (!in_b1 && in_b2) : !in_b2;
    is_last   = (pos_q == last_pos_q);
    pad_char  = (zpad_q && !dot_q) ? CHAR_ZERO : CHAR_SPACE;
    dig_char  = CHAR_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, dig[dig_idx_q]};
    if (in_b1) begin
      ch = left_q ? CHAR_ZERO : pad_char;
    end else if (in_b2) begin
      ch = left_q ? dig_char : CHAR_ZERO;
    end else begin
      ch = left_q ? CHAR_SPACE : dig_char;
    end
  end

  // Sequence one transaction and hold the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      val_q       <= '0;
      bcnt_q      <= '0;
      width_q     <= '0;
      prec_q      <= '0;
      dot_q       <= 1'b0;
      left_q      <= 1'b0;
      zpad_q      <= 1'b0;
      ndig_q      <= '0;
      b1_q        <= '0;
      b2_q        <= '0;
      pos_q       <= '0;
      last_pos_q  <= '0;
      dig_idx_q   <= '0;
      out_valid_q <= 1'b0;
      out_char_q  <= '0;
      out_last_q  <= 1'b0;
    end else begin
      if (!stall_i && state_q != ST_EMIT) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (valid_i) begin
            val_q   <= val_ext[VALUE_BITS-1:0];
            bcnt_q  <= '0;
            width_q <= width_sat;
            prec_q  <= prec_sat;
            dot_q   <= has_precision_i;
            left_q  <= left_justify_i;
            zpad_q  <= pad_with_zero_i;
            state_q <= ST_CONV;
          end
        end
        ST_CONV: begin
          val_q  <= {val_q[VALUE_BITS-2:0], 1'b0};
          bcnt_q <= bcnt_q + 1'b1;
          if (bcnt_q == BCW'(VALUE_BITS - 1)) begin
            state_q <= ST_PREP;
          end
        end
        ST_PREP: begin
          ndig_q  <= ndig_c;
          state_q <= ST_PLAN;
        end
        ST_PLAN: begin
          b1_q       <= b1_c;
          b2_q       <= b2_c;
          pos_q      <= '0;
          last_pos_q <= total - 1'b1;
          dig_idx_q  <= (ndig_q != '0) ? DIW'(ndig_q - 1'b1) : '0;
          state_q    <= (total == '0) ? ST_IDLE : ST_EMIT;
        end
        ST_EMIT: begin
          if (adv) begin
            out_valid_q <= 1'b1;
            out_char_q  <= ch;
            out_last_q  <= is_last;
            pos_q       <= pos_q + 1'b1;
            if (digit_sel) begin
              dig_idx_q <= dig_idx_q - 1'b1;
            end
            if (is_last) begin
              state_q <= ST_IDLE;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  `UDFF_ASSERT_IMP(a_no_digit_overflow, state_q == ST_CONV, !carry[NDIG],
                   "digit row overflowed during conversion")
  `UDFF_ASSERT_IMP(a_pos_in_field, state_q == ST_EMIT, pos_q <= last_pos_q,
                   "emit position ran past the field")
  `UDFF_ASSERT_IMP(a_digit_in_range, state_q == ST_EMIT && digit_sel,
                   NDW'(dig_idx_q) < ndig_q, "digit index beyond significant digits")
  `UDFF_ASSERT_NXT(a_last_ends_item, state_q == ST_EMIT && adv && is_last,
                   state_q == ST_IDLE && out_valid_q && out_last_q,
                   "last character did not end the transaction")

endmodule

`default_nettype wire

>>> bench/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import udff_pkg::*;

  localparam int MAX_FIELD  = MAX_FIELD_DEF;
  localparam int IDLE_LIMIT = 4000;
  localparam int TAIL_WAIT  = 200;
  localparam int HOLD_LEN   = 400;

  typedef struct {
    logic [VALUE_W-1:0] value;
    logic [FIELD_W-1:0] field_width;
    logic [FIELD_W-1:0] min_digits;
    logic               has_precision;
    logic               left_justify;
    logic               pad_with_zero;
  } fmt_item_t;

  typedef struct {
    logic [CHAR_W-1:0] character;
    logic              last_char;
  } char_rec_t;

  logic               clk_i           = 1'b0;
  logic               rst_ni          = 1'b0;
  logic               valid_i         = 1'b0;
  logic [VALUE_W-1:0] value_i         = '0;
  logic [FIELD_W-1:0] field_width_i   = '0;
  logic [FIELD_W-1:0] min_digits_i    = '0;
  logic               has_precision_i = 1'b0;
  logic               left_justify_i  = 1'b0;
  logic               pad_with_zero_i = 1'b0;
  logic               stall_i         = 1'b0;
  logic               stall_o;
  logic               valid_o;
  logic [CHAR_W-1:0]  character_o;
  logic               last_char_o;

  char_rec_t expected_chars[$];
  int        err_count    = 0;
  int        tx_idle_pct  = 0;
  int        rx_stall_pct = 0;
  int        hold_req     = 0;
  int        hold_left    = 0;
  int        quiet_cycles = 0;

  unsigned_decimal_field_formatter dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .valid_i         (valid_i),
    .stall_o         (stall_o),
    .value_i         (value_i),
    .field_width_i   (field_width_i),
    .min_digits_i    (min_digits_i),
    .has_precision_i (has_precision_i),
    .left_justify_i  (left_justify_i),
    .pad_with_zero_i (pad_with_zero_i),
    .valid_o         (valid_o),
    .stall_i         (stall_i),
    .character_o     (character_o),
    .last_char_o     (last_char_o)
  );

  always #5 clk_i = ~clk_i;

  // Expand one item into the characters of its %u field
  function automatic void predict_field_chars(input fmt_item_t it);
    logic [CHAR_W-1:0]  digits[$];
    logic [CHAR_W-1:0]  field[$];
    logic [VALUE_W-1:0] v;
    logic [CHAR_W-1:0]  pad_char;
    int unsigned        width;
    int unsigned        prec;
    int unsigned        zeros;
    int unsigned        body;
    int unsigned        pad;
    char_rec_t          rec;
    v     = it.value;
    width = (it.field_width > MAX_FIELD) ? MAX_FIELD : it.field_width;
    prec  = (it.min_digits > MAX_FIELD) ? MAX_FIELD : it.min_digits;
    // zero with explicit precision zero prints no digits at all
    if (!(it.has_precision && prec == 0 && v == 0)) begin
      do begin
        digits.push_front(CHAR_ZERO + CHAR_W'(v % 10));
        v = v / 10;
      end while (v != 0);
    end
    zeros = (it.has_precision && prec > digits.size()) ? prec - digits.size() : 0;
    body  = zeros + digits.size();
    pad   = (width > body) ? width - body : 0;
    pad_char = (it.pad_with_zero && !it.has_precision) ? CHAR_ZERO : CHAR_SPACE;
    if (!it.left_justify) begin
      repeat (pad) field.push_back(pad_char);
    end
    repeat (zeros) field.push_back(CHAR_ZERO);
    foreach (digits[i]) field.push_back(digits[i]);
    if (it.left_justify) begin
      repeat (pad) field.push_back(CHAR_SPACE);
    end
    foreach (field[i]) begin
      rec.character = field[i];
      rec.last_char = (i == field.size() - 1);
      expected_chars.push_back(rec);
    end
  endfunction

  function automatic fmt_item_t make_item(input logic [VALUE_W-1:0] value,
                                          input int w, input int p,
                                          input int dot, input int left, input int zpad);
    fmt_item_t it;
    it.value         = value;
    it.field_width   = FIELD_W'(w);
    it.min_digits    = FIELD_W'(p);
    it.has_precision = 1'(dot);
    it.left_justify  = 1'(left);
    it.pad_with_zero = 1'(zpad);
    return it;
  endfunction

  // Favor digit-count boundaries, tiny values and the top of the range
  function automatic logic [VALUE_W-1:0] rand_value();
    logic [VALUE_W-1:0] p10;
    p10 = 1;
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $urandom_range(0, 9);
      2: return $urandom_range(0, 99999);
      3: begin
        repeat ($urandom_range(0, 9)) p10 = p10 * 10;
        return p10 - $urandom_range(0, 1);
      end
      4: return {VALUE_W{1'b1}} - $urandom_range(0, 3);
      default: return '0;
    endcase
  endfunction

  // Mostly short fields, sometimes up to the full width
  function automatic fmt_item_t rand_item();
    fmt_item_t it;
    it.value         = rand_value();
    it.field_width   = ($urandom_range(0, 4) == 0) ? FIELD_W'($urandom_range(0, 63))
                                                    : FIELD_W'($urandom_range(0, 12));
    it.min_digits    = ($urandom_range(0, 4) == 0) ? FIELD_W'($urandom_range(0, 63))
                                                    : FIELD_W'($urandom_range(0, 12));
    it.has_precision = 1'($urandom_range(0, 1));
    it.left_justify  = 1'($urandom_range(0, 1));
    it.pad_with_zero = 1'($urandom_range(0, 1));
    return it;
  endfunction

  // Offer one item, hold it until accepted, then record its characters
  task automatic send_field(input fmt_item_t it);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      valid_i <= 1'b0;
      @(posedge clk_i);
    end
    valid_i         <= 1'b1;
    value_i         <= it.value;
    field_width_i   <= it.field_width;
    min_digits_i    <= it.min_digits;
    has_precision_i <= it.has_precision;
    left_justify_i  <= it.left_justify;
    pad_with_zero_i <= it.pad_with_zero;
    do @(posedge clk_i); while (stall_o);
    predict_field_chars(it);
  endtask

  // Pause the sender until every expected character is out
  task automatic drain_fields();
    valid_i <= 1'b0;
    do @(posedge clk_i); while (expected_chars.size() != 0);
  endtask

  task automatic send_random_fields(input int n);
    repeat (n) begin
      if ($urandom_range(0, 39) == 0) drain_fields();
      send_field(rand_item());
    end
  endtask

  task automatic test_directed_fields();
    tx_idle_pct  = 15;
    rx_stall_pct = 45;
    send_field(make_item(32'd0, 0, 0, 0, 0, 0));
    // zero with precision zero: width padding only, or nothing at all
    send_field(make_item(32'd0, 0, 0, 1, 0, 0));
    send_field(make_item(32'd0, 5, 0, 1, 0, 0));
    send_field(make_item(32'd0, 5, 0, 1, 1, 0));
    send_field(make_item(32'd0, 0, 0, 1, 1, 1));
    send_field(make_item(32'hFFFF_FFFF, 0, 0, 0, 0, 0));
    send_field(make_item(32'hFFFF_FFFF, 63, 63, 1, 0, 0));
    // zero-pad is ignored under left-justify and under precision
    send_field(make_item(32'hFFFF_FFFF, 63, 0, 0, 1, 1));
    send_field(make_item(32'd123, 10, 0, 0, 0, 1));
    send_field(make_item(32'd123, 10, 5, 1, 0, 1));
    send_field(make_item(32'd123, 10, 5, 1, 1, 0));
    send_field(make_item(32'd123, 10, 5, 1, 1, 1));
    send_field(make_item(32'd123, 2, 0, 0, 0, 0));
    send_field(make_item(32'd12345, 0, 3, 1, 0, 0));
    send_field(make_item(32'd0, 63, 63, 1, 1, 1));
    send_field(make_item(32'd7, 63, 0, 0, 0, 1));
    send_field(make_item(32'd1000000000, 0, 0, 0, 0, 0));
    send_field(make_item(32'd999999999, 10, 0, 0, 1, 0));
    send_field(make_item(32'd0, 8, 0, 0, 0, 1));
    send_field(make_item(32'd42, 0, 63, 1, 0, 0));
    send_field(make_item(32'd1, 63, 1, 1, 0, 0));
    send_field(make_item(32'd0, 0, 1, 1, 0, 0));
    drain_fields();
  endtask

  task automatic test_random_sender_gaps();
    tx_idle_pct  = 15;
    rx_stall_pct = 45;
    send_random_fields(135);
  endtask

  task automatic test_random_receiver_gaps();
    tx_idle_pct  = 45;
    rx_stall_pct = 15;
    send_random_fields(135);
  endtask

  task automatic test_random_streaming();
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    send_random_fields(135);
  endtask

  // Hold the output off for a long stretch while items keep coming
  task automatic test_output_holdoff();
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    hold_req     = HOLD_LEN;
    send_random_fields(10);
    drain_fields();
  endtask

  // Check each character transaction and drive the receiver stall
  always @(posedge clk_i) begin : char_check
    char_rec_t exp_c;
    if (rst_ni && valid_o && !stall_i) begin
      if (expected_chars.size() == 0) begin
        $error("unexpected character %h (last_char %b)", character_o, last_char_o);
        err_count++;
      end else begin
        exp_c = expected_chars.pop_front();
        if (character_o !== exp_c.character) begin
          $error("character: expected %h, actual %h", exp_c.character, character_o);
          err_count++;
        end
        if (last_char_o !== exp_c.last_char) begin
          $error("last_char: expected %b, actual %b", exp_c.last_char, last_char_o);
          err_count++;
        end
      end
    end
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left != 0) begin
      stall_i <= 1'b1;
      hold_left--;
    end else begin
      stall_i <= ($urandom_range(0, 99) < rx_stall_pct);
    end
  end

  // Abort when no transaction moves on either side for too long
  always @(posedge clk_i) begin
    if ((valid_i && !stall_o) || (valid_o && !stall_i) || !rst_ni) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("[unsigned_decimal_field_formatter] ERROR");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_fields();
    test_random_sender_gaps();
    test_random_receiver_gaps();
    test_output_holdoff();
    test_random_streaming();
    drain_fields();
    // let any trailing activity show up before judging
    repeat (TAIL_WAIT) @(posedge clk_i);
    if (err_count == 0) begin
      $display("[unsigned_decimal_field_formatter] OK");
    end else begin
      $display("[unsigned_decimal_field_formatter] ERROR");
    end
    $finish;
  end

endmodule
